[rtl/core/mte_pkg.sv]
`default_nettype none

package mte_pkg;

    localparam int SLOT_BITS = 4;
    localparam int TASK_BITS = 8;
    localparam int KEY_FIELD_BITS = 32;
    localparam int Q_DEPTH = 2;

    localparam logic [2:0] MODE_DECLARE = 3'd0;
    localparam logic [2:0] MODE_LOCK    = 3'd1;
    localparam logic [2:0] MODE_UNLOCK  = 3'd2;
    localparam logic [2:0] MODE_QKEY    = 3'd3;
    localparam logic [2:0] MODE_QSLOT   = 3'd4;
    localparam logic [2:0] MODE_REMOVE  = 3'd5;

    localparam logic [1:0] CALLER_TASK = 2'd0;
    localparam logic [1:0] CALLER_MAIN = 2'd1;

    typedef enum logic [2:0] {
        OP_DECLARE,
        OP_LOCK,
        OP_UNLOCK,
        OP_QKEY,
        OP_QSLOT,
        OP_REMOVE,
        OP_BAD
    } op_t;

    typedef enum logic [3:0] {
        RS_OK,
        RS_NOT_FOUND,
        RS_FULL,
        RS_DUPLICATE,
        RS_BUSY,
        RS_BAD_CALLER,
        RS_NOT_PERMITTED,
        RS_ALREADY_UNLOCKED,
        RS_NOT_OWNER,
        RS_BAD_SLOT
    } status_t;

    typedef enum logic [1:0] {
        LS_UNLOCKED,
        LS_LOCKED,
        LS_DISABLED
    } lock_state_t;

    typedef enum logic [1:0] {
        OWN_NONE,
        OWN_TASK,
        OWN_MAIN
    } owner_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_KEY_RD,
        B_KEY_CMP
    } back_state_t;

    typedef struct packed {
        op_t                       op;
        logic [KEY_FIELD_BITS-1:0] key;
        logic [SLOT_BITS-1:0]      slot;
        logic [1:0]                kind;
        logic [TASK_BITS-1:0]      task_id;
        logic                      permitted;
    } job_t;

    typedef struct packed {
        lock_state_t          st;
        owner_t               kind;
        logic [TASK_BITS-1:0] owner_task;
    } entry_t;

    localparam entry_t NEW_ENTRY = '{st: LS_UNLOCKED, kind: OWN_NONE, owner_task: '0};

endpackage

`default_nettype wire

[rtl/core/mte_if.sv]
`default_nettype none

interface mte_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [31:0] lock_key;
    logic [3:0] slot_number;
    logic [1:0] caller_kind;
    logic [7:0] caller_task;
    logic       task_permitted;

    modport source (
        output valid, mode, lock_key, slot_number, caller_kind, caller_task,
               task_permitted,
        input  ready
    );
    modport sink (
        input  valid, mode, lock_key, slot_number, caller_kind, caller_task,
               task_permitted,
        output ready
    );
endinterface

interface mte_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic       is_locked;
    logic [1:0] entry_state;
    logic [1:0] entry_owner_kind;
    logic [7:0] entry_owner_task;
    logic [3:0] entry_slot;

    modport source (
        output valid, status, is_locked, entry_state, entry_owner_kind,
               entry_owner_task, entry_slot,
        input  ready
    );
    modport sink (
        input  valid, status, is_locked, entry_state, entry_owner_kind,
               entry_owner_task, entry_slot,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/mte_front.sv]
`default_nettype none

module mte_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    mte_req_if.sink           req,
    output mte_pkg::job_t     job,
    output logic              job_valid,
    input  wire logic         job_pop
);
    import mte_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNTW = $clog2(Q_DEPTH + 1);

    job_t            q_mem [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    job_t            in_job;
    logic            push;
    logic            pop;

    always_comb
    begin
        in_job.key       = req.lock_key;
        in_job.slot      = req.slot_number;
        in_job.kind      = req.caller_kind;
        in_job.task_id   = req.caller_task;
        in_job.permitted = req.task_permitted;
        case (req.mode)
            MODE_DECLARE: in_job.op = OP_DECLARE;
            MODE_LOCK:    in_job.op = OP_LOCK;
            MODE_UNLOCK:  in_job.op = OP_UNLOCK;
            MODE_QKEY:    in_job.op = OP_QKEY;
            MODE_QSLOT:   in_job.op = OP_QSLOT;
            MODE_REMOVE:  in_job.op = OP_REMOVE;
            default:      in_job.op = OP_BAD;
        endcase
    end

    assign req.ready = (count_reg != CNTW'(Q_DEPTH));
    assign push      = req.valid && req.ready;
    assign job_valid = (count_reg != '0);
    assign pop       = job_pop && job_valid;
    assign job       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mte_back.sv]
`default_nettype none

module mte_back #(
    parameter int ENTRIES      = 16,
    parameter int KEY_BITS     = 32,
    parameter int TASK_ID_BITS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire mte_pkg::job_t job,
    input  wire logic         job_valid,
    output logic              job_pop,
    mte_rsp_if.source         rsp
);
    import mte_pkg::*;

    localparam int KB = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;
    localparam int TB = (TASK_ID_BITS < TASK_BITS) ? TASK_ID_BITS : TASK_BITS;
    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW = $clog2(ENTRIES + 1);
    localparam int CW = (UW > SLOT_BITS) ? UW : SLOT_BITS;

    logic [KB-1:0] key_mem [ENTRIES];
    entry_t        ent_mem [ENTRIES];
    logic [KB-1:0] key_q;
    entry_t        ent_q;

    back_state_t   state_reg, state_next;
    job_t          job_reg, job_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [UW-1:0] used_reg, used_next;

    logic          key_we;
    logic [KB-1:0] key_wdata;
    logic          ent_we;
    logic [SW-1:0] wr_idx;
    entry_t        ent_wdata;

    logic          start;
    logic          launch;
    logic          full;
    logic          bad_slot;
    logic          found;
    logic          last;

    entry_t        ex_ent;
    status_t       ex_status;
    logic          ex_we;
    logic [TASK_BITS-1:0] ex_task;

    logic          res_load;
    status_t       res_status;
    logic          res_hit;
    entry_t        res_ent;
    logic [SW-1:0] res_slot;

    logic          rsp_valid_reg;
    status_t       rsp_status_reg;
    entry_t        rsp_ent_reg;
    logic [SLOT_BITS-1:0] rsp_slot_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_idx] <= key_wdata;
        end
        key_q <= key_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[wr_idx] <= ent_wdata;
        end
        ent_q <= ent_mem[idx_reg];
    end

    always_comb
    begin
        start    = (state_reg == B_IDLE) && job_valid && (!rsp_valid_reg || rsp.ready);
        full     = (used_reg == UW'(ENTRIES));
        bad_slot = (CW'(job.slot) >= CW'(used_reg));
        case (job.op)
            OP_DECLARE: launch = !full && (used_reg != '0);
            OP_QSLOT:   launch = !bad_slot;
            OP_BAD:     launch = 1'b0;
            default:    launch = (used_reg != '0);
        endcase
        found = (job_reg.op == OP_QSLOT) || (key_q == job_reg.key[KB-1:0]);
        last  = ((UW'(idx_reg) + UW'(1)) == used_reg);
    end

    always_comb
    begin
        ex_task   = TASK_BITS'(job_reg.task_id[TB-1:0]);
        ex_ent    = ent_q;
        ex_status = RS_OK;
        ex_we     = 1'b0;
        case (job_reg.op)
            OP_DECLARE:
            begin
                ex_status = RS_DUPLICATE;
            end
            OP_LOCK:
            begin
                if (ent_q.st == LS_LOCKED)
                begin
                    ex_status = RS_BUSY;
                end
                else if (job_reg.kind == CALLER_TASK)
                begin
                    if (!job_reg.permitted)
                    begin
                        ex_status = RS_NOT_PERMITTED;
                    end
                    else
                    begin
                        ex_ent.st         = LS_LOCKED;
                        ex_ent.kind       = OWN_TASK;
                        ex_ent.owner_task = ex_task;
                        ex_we             = 1'b1;
                    end
                end
                else if (job_reg.kind == CALLER_MAIN)
                begin
                    ex_ent.st         = LS_LOCKED;
                    ex_ent.kind       = OWN_MAIN;
                    ex_ent.owner_task = '0;
                    ex_we             = 1'b1;
                end
                else
                begin
                    ex_status = RS_BAD_CALLER;
                end
            end
            OP_UNLOCK:
            begin
                if (ent_q.st == LS_UNLOCKED)
                begin
                    ex_status = RS_ALREADY_UNLOCKED;
                end
                else if (job_reg.kind == CALLER_TASK)
                begin
                    if (ent_q.kind != OWN_TASK || ent_q.owner_task != ex_task)
                    begin
                        ex_status = RS_NOT_OWNER;
                    end
                    else
                    begin
                        ex_ent.st = LS_UNLOCKED;
                        ex_we     = 1'b1;
                    end
                end
                else if (job_reg.kind == CALLER_MAIN)
                begin
                    if (ent_q.kind != OWN_MAIN || ent_q.owner_task != '0)
                    begin
                        ex_status = RS_NOT_OWNER;
                    end
                    else
                    begin
                        ex_ent.st = LS_UNLOCKED;
                        ex_we     = 1'b1;
                    end
                end
                else
                begin
                    ex_status = RS_BAD_CALLER;
                end
            end
            OP_REMOVE:
            begin
                if (ent_q.st == LS_LOCKED)
                begin
                    ex_status = RS_BUSY;
                end
                else
                begin
                    ex_ent.st = LS_DISABLED;
                    ex_we     = 1'b1;
                end
            end
            default:
            begin
                ex_status = RS_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (start && launch)
                begin
                    state_next = B_KEY_RD;
                end
            end
            B_KEY_RD:
            begin
                state_next = B_KEY_CMP;
            end
            B_KEY_CMP:
            begin
                state_next = (!found && !last) ? B_KEY_RD : B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_pop    = 1'b0;
        job_next   = job_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        key_we     = 1'b0;
        key_wdata  = job_reg.key[KB-1:0];
        ent_we     = 1'b0;
        wr_idx     = idx_reg;
        ent_wdata  = ex_ent;
        res_load   = 1'b0;
        res_status = RS_OK;
        res_hit    = 1'b0;
        res_ent    = ent_q;
        res_slot   = idx_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    job_pop  = 1'b1;
                    job_next = job;
                    idx_next = '0;
                    case (job.op)
                        OP_DECLARE:
                        begin
                            if (full)
                            begin
                                res_load   = 1'b1;
                                res_status = RS_FULL;
                            end
                            else if (used_reg == '0)
                            begin
                                key_we     = 1'b1;
                                key_wdata  = job.key[KB-1:0];
                                ent_we     = 1'b1;
                                wr_idx     = SW'(used_reg);
                                ent_wdata  = NEW_ENTRY;
                                used_next  = used_reg + UW'(1);
                                res_load   = 1'b1;
                                res_hit    = 1'b1;
                                res_ent    = NEW_ENTRY;
                                res_slot   = SW'(used_reg);
                            end
                        end
                        OP_QSLOT:
                        begin
                            if (bad_slot)
                            begin
                                res_load   = 1'b1;
                                res_status = RS_BAD_SLOT;
                            end
                            else
                            begin
                                idx_next = SW'(job.slot);
                            end
                        end
                        OP_BAD:
                        begin
                            res_load   = 1'b1;
                            res_status = RS_NOT_FOUND;
                        end
                        default:
                        begin
                            if (used_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res_status = RS_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            B_KEY_CMP:
            begin
                if (found)
                begin
                    ent_we     = ex_we;
                    wr_idx     = idx_reg;
                    ent_wdata  = ex_ent;
                    res_load   = 1'b1;
                    res_status = ex_status;
                    res_hit    = 1'b1;
                    res_ent    = ex_ent;
                    res_slot   = idx_reg;
                end
                else if (last)
                begin
                    res_load = 1'b1;
                    if (job_reg.op == OP_DECLARE)
                    begin
                        key_we    = 1'b1;
                        key_wdata = job_reg.key[KB-1:0];
                        ent_we    = 1'b1;
                        wr_idx    = SW'(used_reg);
                        ent_wdata = NEW_ENTRY;
                        used_next = used_reg + UW'(1);
                        res_hit   = 1'b1;
                        res_ent   = NEW_ENTRY;
                        res_slot  = SW'(used_reg);
                    end
                    else
                    begin
                        res_status = RS_NOT_FOUND;
                    end
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            default:
            begin
                job_next = job_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (res_load)
        begin
            rsp_status_reg <= res_status;
            rsp_ent_reg    <= res_hit ? res_ent : '0;
            rsp_slot_reg   <= res_hit ? SLOT_BITS'(res_slot) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            used_reg  <= used_next;
            if (res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_status_reg;
    assign rsp.is_locked        = (rsp_ent_reg.st == LS_LOCKED);
    assign rsp.entry_state      = rsp_ent_reg.st;
    assign rsp.entry_owner_kind = rsp_ent_reg.kind;
    assign rsp.entry_owner_task = rsp_ent_reg.owner_task;
    assign rsp.entry_slot       = rsp_slot_reg;

endmodule

`default_nettype wire

[rtl/core/mutex_table_engine_top.sv]
// Mutex table engine. Requests arrive on the req channel and each one yields
// exactly one transaction on the rsp channel, in request order. Both channels
// use valid/ready; a transaction completes on a clock edge with both high.
// A request enters a two-deep queue and is decoded there; the engine behind
// the queue then serves one request at a time from its key and entry tables.
// A request needs no table search when it is a declare into a full table, a
// query by slot out of range, an unused mode, or any request on an empty
// table; a query by slot in range reads only that entry. Otherwise the key
// search reads the used entries in order, one at a time through a registered
// memory port, and stops at the first key match or after the last used entry.
// The next request starts once the previous response has been taken or is
// taken in that cycle, and the queue keeps accepting requests meanwhile.
// When the receiver stalls, the response holds and the queue fills, after
// which req.ready falls.
// Reset empties the table and the queue; table contents are not cleared, and
// only entries written by a declare are ever read.
`default_nettype none

module mutex_table_engine_top #(
    parameter int ENTRIES      = 16,
    parameter int KEY_BITS     = 32,
    parameter int TASK_ID_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mte_req_if.sink   req,
    mte_rsp_if.source rsp
);
    import mte_pkg::*;

    job_t job;
    logic job_valid;
    logic job_pop;

    mte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop)
    );

    mte_back #(
        .ENTRIES      (ENTRIES),
        .KEY_BITS     (KEY_BITS),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
